/* hdl/windowed_dct_8x8_assert.svh */
// Assertion macros for the windowed 8x8 DCT block
`ifndef WINDOWED_DCT_8X8_ASSERT_SVH
`define WINDOWED_DCT_8X8_ASSERT_SVH
// implication checked on every clock edge outside reset
`define WDCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%s failed", "lbl");
// next-cycle implication
`define WDCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%s failed", "lbl");
`endif

/* hdl/wdct_pkg.sv */
// Package: types, constants and tables of the windowed 8x8 DCT
package wdct_pkg;
  localparam int SampleBits = 12;
  localparam int ConstFracBits = 14;
  localparam int CoefBits = 24;
  localparam int AccBits = 40;
  localparam int MulBits = 20;
  // multiplier data operand: column-pass values stay below 2^27 in magnitude
  localparam int MulABits = 28;
  localparam int ProdBits = MulABits + MulBits;

  typedef logic signed [AccBits-1:0] acc_t;

  // constant select codes
  typedef enum logic [1:0] {
    K_C707, K_C383, K_C541, K_C1307
  } kconst_e;

  typedef enum logic [2:0] {
    ST_LOAD, ST_READ, ST_LANE, ST_CALC, ST_WRITE, ST_EMIT
  } state_e;

  // butterfly micro-op: dst = a op b, or dst = round(a*k)
  typedef enum logic [1:0] {
    OP_ADD, OP_SUB, OP_MUL
  } op_e;

  typedef struct packed {
    op_e     op;
    logic [4:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
    kconst_e kc;
  } uop_t;

  localparam int NumUops = 30;

  function automatic logic signed [MulBits-1:0] kconst(kconst_e k);
    logic signed [MulBits-1:0] r;
    case (k)
      K_C707:  r = MulBits'(11585);
      K_C383:  r = MulBits'(6270);
      K_C541:  r = MulBits'(8867);
      K_C1307: r = MulBits'(21407);
      default: r = '0;
    endcase
    return r;
  endfunction

  // window quadrant in Q2.14
  function automatic logic signed [MulBits-1:0] window_q(logic [2:0] v, logic [2:0] u);
    logic [1:0] fv, fu;
    logic signed [MulBits-1:0] r;
    fv = v[2] ? ~v[1:0] : v[1:0];
    fu = u[2] ? ~u[1:0] : u[1:0];
    case ({fv, fu})
      4'h0: r = MulBits'(3814);  4'h1: r = MulBits'(7168);
      4'h2: r = MulBits'(9657);  4'h3: r = MulBits'(10981);
      4'h4: r = MulBits'(7168);  4'h5: r = MulBits'(13471);
      4'h6: r = MulBits'(18149); 4'h7: r = MulBits'(20637);
      4'h8: r = MulBits'(9657);  4'h9: r = MulBits'(18149);
      4'hA: r = MulBits'(24451); 4'hB: r = MulBits'(27805);
      4'hC: r = MulBits'(10981); 4'hD: r = MulBits'(20637);
      4'hE: r = MulBits'(27805); default: r = MulBits'(31618);
    endcase
    return r;
  endfunction

  // registers: 0..7 data, 8.. temporaries, outputs kept in 0..7 as o[k]
  // s0=8 s1=9 s2=10 s3=11 e7=12 e6=13 e5=14 e4=15 a=16 b=17 c=18 e=19
  // t=20 z1=21 p=22 q=23 r=24 z5=25 z2=26 z4=27 z3=28 z11=29 z13=30
  function automatic uop_t uop(logic [4:0] i);
    uop_t u;
    u = '{OP_ADD, 5'd0, 5'd0, 5'd0, K_C707};
    case (i)
      5'd0:  u = '{OP_ADD, 5'd8,  5'd0, 5'd7, K_C707};
      5'd1:  u = '{OP_ADD, 5'd9,  5'd1, 5'd6, K_C707};
      5'd2:  u = '{OP_ADD, 5'd10, 5'd2, 5'd5, K_C707};
      5'd3:  u = '{OP_ADD, 5'd11, 5'd3, 5'd4, K_C707};
      5'd4:  u = '{OP_SUB, 5'd12, 5'd0, 5'd7, K_C707};
      5'd5:  u = '{OP_SUB, 5'd13, 5'd1, 5'd6, K_C707};
      5'd6:  u = '{OP_SUB, 5'd14, 5'd2, 5'd5, K_C707};
      5'd7:  u = '{OP_SUB, 5'd15, 5'd3, 5'd4, K_C707};
      5'd8:  u = '{OP_ADD, 5'd16, 5'd8, 5'd11, K_C707};
      5'd9:  u = '{OP_SUB, 5'd17, 5'd8, 5'd11, K_C707};
      5'd10: u = '{OP_ADD, 5'd18, 5'd9, 5'd10, K_C707};
      5'd11: u = '{OP_SUB, 5'd19, 5'd9, 5'd10, K_C707};
      5'd12: u = '{OP_ADD, 5'd0,  5'd16, 5'd18, K_C707};
      5'd13: u = '{OP_SUB, 5'd4,  5'd16, 5'd18, K_C707};
      5'd14: u = '{OP_ADD, 5'd20, 5'd19, 5'd17, K_C707};
      5'd15: u = '{OP_MUL, 5'd21, 5'd20, 5'd0, K_C707};
      5'd16: u = '{OP_ADD, 5'd2,  5'd17, 5'd21, K_C707};
      5'd17: u = '{OP_SUB, 5'd6,  5'd17, 5'd21, K_C707};
      5'd18: u = '{OP_ADD, 5'd22, 5'd15, 5'd14, K_C707};
      5'd19: u = '{OP_ADD, 5'd23, 5'd14, 5'd13, K_C707};
      5'd20: u = '{OP_ADD, 5'd24, 5'd13, 5'd12, K_C707};
      5'd21: u = '{OP_SUB, 5'd20, 5'd22, 5'd24, K_C707};
      5'd22: u = '{OP_MUL, 5'd25, 5'd20, 5'd0, K_C383};
      5'd23: u = '{OP_MUL, 5'd26, 5'd22, 5'd0, K_C541};
      5'd24: u = '{OP_ADD, 5'd26, 5'd26, 5'd25, K_C707};
      5'd25: u = '{OP_MUL, 5'd27, 5'd24, 5'd0, K_C1307};
      5'd26: u = '{OP_ADD, 5'd27, 5'd27, 5'd25, K_C707};
      5'd27: u = '{OP_MUL, 5'd28, 5'd23, 5'd0, K_C707};
      5'd28: u = '{OP_ADD, 5'd29, 5'd12, 5'd28, K_C707};
      default: u = '{OP_SUB, 5'd30, 5'd12, 5'd28, K_C707};
    endcase
    return u;
  endfunction

  // final four outputs done in the lane (finish) phase: o5,o3,o1,o7
  function automatic uop_t fin(logic [1:0] i);
    uop_t u;
    case (i)
      2'd0: u = '{OP_ADD, 5'd5, 5'd30, 5'd26, K_C707};
      2'd1: u = '{OP_SUB, 5'd3, 5'd30, 5'd26, K_C707};
      2'd2: u = '{OP_ADD, 5'd1, 5'd29, 5'd27, K_C707};
      default: u = '{OP_SUB, 5'd7, 5'd29, 5'd27, K_C707};
    endcase
    return u;
  endfunction

  function automatic logic signed [CoefBits-1:0] sat(acc_t v);
    logic signed [CoefBits-1:0] r;
    if (v > acc_t'(8388607)) r = CoefBits'(8388607);
    else if (v < -acc_t'(8388608)) r = CoefBits'(-8388608);
    else r = v[CoefBits-1:0];
    return r;
  endfunction
endpackage

/* hdl/wdct_stream_if.sv */
// Valid/ready stream interface
interface wdct_stream_if #(parameter int W = 12);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/wdct_alu.sv */
// Shared add/sub/multiply-round unit of the butterfly
module wdct_alu (
  input  wdct_pkg::op_e  op_i,
  input  wdct_pkg::acc_t a_i,
  input  wdct_pkg::acc_t b_i,
  input  logic signed [wdct_pkg::MulBits-1:0] k_i,
  output wdct_pkg::acc_t y_o
);
  logic signed [wdct_pkg::MulABits-1:0] a_mul;
  logic signed [wdct_pkg::ProdBits-1:0] prod;
  logic signed [wdct_pkg::ProdBits-1:0] rnd;
  // operands of multiply fit in 28 bits x 20 bits
  assign a_mul = a_i[wdct_pkg::MulABits-1:0];
  assign prod = wdct_pkg::ProdBits'(a_mul) * wdct_pkg::ProdBits'(k_i);
  assign rnd  = prod + wdct_pkg::ProdBits'(1 << (wdct_pkg::ConstFracBits - 1));
  always_comb begin
    case (op_i)
      wdct_pkg::OP_ADD: y_o = a_i + b_i;
      wdct_pkg::OP_SUB: y_o = a_i - b_i;
      wdct_pkg::OP_MUL: y_o = wdct_pkg::AccBits'(rnd >>> wdct_pkg::ConstFracBits);
      default: y_o = '0;
    endcase
  end
endmodule

/* hdl/windowed_dct_8x8.sv */
// Top level: windowed 8x8 DCT on one shared butterfly unit
//  channel | dir | fields
//  in_s    | in  | sample[11:0]
//  out_m   | out | coefficient[23:0], last (packed {coefficient,last})
// Load: one sample per cycle while in valid is high, 64 beats. Then 16 lines (8 rows,
// 8 columns), each a read of the 8 lanes, 30 unit ops, 4 finish ops and 8 writes.
// Emit: 64 beats; out valid drops after each accepted beat. The block period
// without stalls is set by the shared ALU and the emit.
// in ready only while loading; out stalls lengthen the emit. Reset clears control only.
`include "windowed_dct_8x8_assert.svh"
module windowed_dct_8x8 (
  input  logic clk_i,
  input  logic rst_ni,
  wdct_stream_if.sink   in_s,
  wdct_stream_if.source out_m
);
  wdct_pkg::state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;      // load / emit index
  logic [3:0] line_q, line_d;    // 0..7 rows, 8..15 columns
  logic [4:0] step_q, step_d;
  logic signed [wdct_pkg::SampleBits-1:0] smem [64];
  logic signed [wdct_pkg::CoefBits-1:0] pmem [64];
  logic signed [wdct_pkg::CoefBits-1:0] cmem [64];
  wdct_pkg::acc_t rf_q [31];
  logic signed [wdct_pkg::SampleBits-1:0] srd_q;
  logic signed [wdct_pkg::CoefBits-1:0] prd_q, crd_q;
  logic rd_vld_q;
  logic out_valid_q;

  wdct_pkg::uop_t u;
  wdct_pkg::op_e alu_op;
  wdct_pkg::acc_t alu_a, alu_b, alu_y;
  logic signed [wdct_pkg::MulBits-1:0] alu_k;
  logic [5:0] rd_addr, wr_addr;
  logic col;
  logic [2:0] lane;
  logic [2:0] ld_lane;

  assign col = line_q[3];
  assign lane = step_q[2:0];
  assign ld_lane = step_q[2:0] - 3'd1;
  assign rd_addr = col ? {lane, line_q[2:0]} : {line_q[2:0], lane};
  assign wr_addr = rd_addr;

  wdct_alu u_alu (.op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .k_i(alu_k), .y_o(alu_y));

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    line_d = line_q;
    step_d = step_q;
    u = wdct_pkg::uop(step_q);
    alu_op = u.op; alu_a = rf_q[u.sa]; alu_b = rf_q[u.sb];
    alu_k = wdct_pkg::kconst(u.kc);
    case (state_q)
      wdct_pkg::ST_LOAD: begin
        if (in_s.valid) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            state_d = wdct_pkg::ST_READ; line_d = '0; step_d = '0;
          end
        end
      end
      wdct_pkg::ST_READ: begin
        // step 0..8: issue read of lane step, capture previous
        if (step_q == 5'd8) begin
          state_d = wdct_pkg::ST_CALC; step_d = '0;
        end else step_d = step_q + 5'd1;
      end
      wdct_pkg::ST_CALC: begin
        if (step_q == 5'(wdct_pkg::NumUops - 1)) begin
          state_d = wdct_pkg::ST_LANE; step_d = '0;
        end else step_d = step_q + 5'd1;
      end
      wdct_pkg::ST_LANE: begin
        u = wdct_pkg::fin(step_q[1:0]);
        alu_op = u.op; alu_a = rf_q[u.sa]; alu_b = rf_q[u.sb];
        if (step_q == 5'd3) begin
          state_d = wdct_pkg::ST_WRITE; step_d = '0;
        end else step_d = step_q + 5'd1;
      end
      wdct_pkg::ST_WRITE: begin
        // column pass: window multiply of lane output
        alu_op = wdct_pkg::OP_MUL;
        alu_a = rf_q[{2'b00, lane}];
        alu_k = wdct_pkg::window_q(lane, line_q[2:0]);
        if (step_q == 5'd7) begin
          step_d = '0;
          line_d = line_q + 4'd1;
          state_d = (line_q == 4'd15) ? wdct_pkg::ST_EMIT : wdct_pkg::ST_READ;
          cnt_d = '0;
        end else step_d = step_q + 5'd1;
      end
      wdct_pkg::ST_EMIT: begin
        if (out_valid_q && out_m.ready) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_d = wdct_pkg::ST_LOAD;
        end
      end
      default: state_d = wdct_pkg::ST_LOAD;
    endcase
  end

  assign in_s.ready = (state_q == wdct_pkg::ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wdct_pkg::ST_LOAD;
      cnt_q <= '0; line_q <= '0; step_q <= '0;
      rd_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; line_q <= line_d; step_q <= step_d;
      rd_vld_q <= (state_q == wdct_pkg::ST_READ) && (step_q != 5'd8);
      // emit read: crd_q is registered from cnt_d; valid rises after it and drops after each accepted beat
      if (state_q == wdct_pkg::ST_EMIT) begin
        if (out_valid_q && out_m.ready) out_valid_q <= 1'b0;
        else out_valid_q <= 1'b1;
      end else out_valid_q <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) smem[cnt_q] <= in_s.data;
    srd_q <= smem[rd_addr];
    prd_q <= pmem[rd_addr];
    crd_q <= cmem[cnt_d];
    if (state_q == wdct_pkg::ST_WRITE) begin
      if (!col) pmem[wr_addr] <= wdct_pkg::sat(rf_q[{2'b00, lane}]);
      else cmem[{lane, line_q[2:0]}] <= wdct_pkg::sat(alu_y);
    end
  end

  // register file of the butterfly
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      rf_q[{2'b00, ld_lane}] <= col ? wdct_pkg::acc_t'(prd_q)
                                    : wdct_pkg::acc_t'($signed({srd_q, 4'b0000}));
    end
    if (state_q == wdct_pkg::ST_CALC || state_q == wdct_pkg::ST_LANE) rf_q[u.dst] <= alu_y;
  end

  assign out_m.valid = out_valid_q;
  assign out_m.data = {crd_q, (cnt_q == 6'd63)};

  `WDCT_ASSERT_IMP(a_noin_busy, clk_i, rst_ni, state_q != wdct_pkg::ST_LOAD, !in_s.ready)
  `WDCT_ASSERT_IMP(a_out_emit, clk_i, rst_ni, out_m.valid, state_q == wdct_pkg::ST_EMIT)
  `WDCT_ASSERT_NXT(a_load_done, clk_i, rst_ni,
    in_s.valid && in_s.ready && cnt_q == 6'd63, state_q == wdct_pkg::ST_READ)
endmodule
